// File: rtl/core/fli_byte_run_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// fli_byte_run_decoder_top_defines
// Assertion macros shared by the byte-run decoder RTL.
// ----------------------------------------------------------------------------
`ifndef FLI_BYTE_RUN_DECODER_TOP_DEFINES_SVH
`define FLI_BYTE_RUN_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked while out of reset
`define FBRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fbrd assertion failed");

// checked at every edge, reset included
`define FBRD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fbrd assertion failed");

`else

`define FBRD_ASSERT(lbl, prop)
`define FBRD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: rtl/core/fbrd_pkg.sv
// ----------------------------------------------------------------------------
// fbrd_pkg
// Widths, register map, reset values and the command type of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fbrd_pkg;

  localparam int unsigned CFG_W      = 13;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned RUN_W      = 7;
  localparam int unsigned LIT_W      = 8;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned MAX_LINE_PIXELS_DEF = 4096;
  localparam int unsigned MAX_LINES_DEF       = 4096;

  localparam int unsigned FRAME_WIDTH_RST  = 320;
  localparam int unsigned FRAME_HEIGHT_RST = 200;

  // bit of an opcode that marks a literal run
  localparam int unsigned OPC_LITERAL_BIT = 7;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // one frame buffer write; address is line_base + col_lo, mod 2^24
  typedef struct packed {
    logic [ADDR_W-1:0] line_base;
    logic [ADDR_W-1:0] col_lo;
    logic [BYTE_W-1:0] value;
    logic [RUN_W-1:0]  count;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/fbrd_if.sv
// ----------------------------------------------------------------------------
// fbrd_if
// Valid/ready channels of the decoder: chunk bytes in, frame writes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbrd_in_if;
  import fbrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] chunk_byte;
  logic              chunk_last;

  modport source (output valid, output chunk_byte, output chunk_last, input ready);
  modport sink   (input valid, input chunk_byte, input chunk_last, output ready);
endinterface

interface fbrd_out_if;
  import fbrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [BYTE_W-1:0] pixel_value;
  logic [RUN_W-1:0]  run_count;

  modport source (output valid, output write_address, output pixel_value,
                  output run_count, input ready);
  modport sink   (input valid, input write_address, input pixel_value,
                  input run_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fbrd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fbrd_cmd_fifo
// Short command queue between the decode front and the output back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fli_byte_run_decoder_top_defines.svh"

module fbrd_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fbrd_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output fbrd_pkg::cmd_t     head
);
  import fbrd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `FBRD_ASSERT(a_no_push_when_full, push |-> !full)
  `FBRD_ASSERT(a_no_pop_when_empty, pop |-> valid)
  `FBRD_ASSERT(a_count_in_range, count_r <= CNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// File: rtl/core/fbrd_front.sv
// ----------------------------------------------------------------------------
// fbrd_front
// Register port and byte-run decode: tracks line, column and opcode phase
// and pushes one write command per literal byte or clipped fill.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fli_byte_run_decoder_top_defines.svh"

module fbrd_front #(
  parameter int unsigned MAX_LINE_PIXELS = fbrd_pkg::MAX_LINE_PIXELS_DEF,
  parameter int unsigned MAX_LINES       = fbrd_pkg::MAX_LINES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fbrd_in_if.sink                              in_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fbrd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [fbrd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [fbrd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output logic                                 cmd_push,
  output fbrd_pkg::cmd_t                       cmd,
  input  wire logic                            q_full
);
  import fbrd_pkg::*;

  localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
  localparam int unsigned W_LIM   = (MAX_LINE_PIXELS < CFG_MAX) ? MAX_LINE_PIXELS : CFG_MAX;
  localparam int unsigned H_LIM   = (MAX_LINES < CFG_MAX) ? MAX_LINES : CFG_MAX;
  localparam int unsigned ROOM_W  = $clog2(W_LIM * H_LIM + 1);
  localparam int unsigned RST_W   = (FRAME_WIDTH_RST < W_LIM) ? FRAME_WIDTH_RST : W_LIM;
  localparam int unsigned RST_H   = (FRAME_HEIGHT_RST < H_LIM) ? FRAME_HEIGHT_RST : H_LIM;
  localparam int unsigned RST_ROOM = RST_W * RST_H;
  localparam logic [1:0]  RECALC_CYCLES = 2'd2;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_OPCODE,
    PH_LITERAL,
    PH_FILL
  } phase_t;

  logic [CFG_W-1:0]  frame_width_r, frame_width_nxt;
  logic [CFG_W-1:0]  frame_height_r, frame_height_nxt;
  logic [CFG_W-1:0]  w_r, w_nxt;
  logic [CFG_W-1:0]  h_r, h_nxt;
  logic [ROOM_W-1:0] wh_r, wh_nxt;
  logic [CFG_W-1:0]  rem_lines_r, rem_lines_nxt;
  logic [ROOM_W-1:0] room_r, room_nxt;
  logic [1:0]        recalc_r, recalc_nxt;

  logic [CFG_W-1:0]  line_index_r, line_index_nxt;
  logic [ADDR_W-1:0] line_base_r, line_base_nxt;
  logic [ROOM_W-1:0] column_r, column_nxt;
  phase_t            phase_r, phase_nxt;
  logic [LIT_W-1:0]  literal_left_r, literal_left_nxt;
  logic [RUN_W-1:0]  repeat_r, repeat_nxt;

  logic              cfg_wr;
  logic              accept;
  logic              chunk_end;
  logic              active;
  logic [ROOM_W-1:0] w_ext;
  logic [ROOM_W-1:0] space;
  logic              col_lt_room;
  logic [ROOM_W-1:0] col_inc;
  logic [RUN_W-1:0]  fill_len;
  logic [CFG_W-1:0]  wdata;

  assign cfg_wr      = psel & penable & pwrite;
  assign pready      = 1'b1;
  assign in_ch.ready = (recalc_r == '0) & ~q_full;
  assign accept      = in_ch.valid & in_ch.ready;
  assign chunk_end   = accept & in_ch.chunk_last;
  assign active      = (line_index_r < h_r);
  assign w_ext       = ROOM_W'(w_r);
  assign col_lt_room = (column_r < room_r);
  assign space       = room_r - column_r;
  assign col_inc     = column_r + ROOM_W'(1);
  assign wdata       = pwdata[CFG_W-1:0];

  always_comb begin
    if (!col_lt_room) begin
      fill_len = '0;
    end else if (ROOM_W'(repeat_r) < space) begin
      fill_len = repeat_r;
    end else begin
      fill_len = space[RUN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    logic [LIT_W-1:0]  lit;
    logic [ROOM_W-1:0] col_after;
    logic              adv;

    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    w_nxt            = w_r;
    h_nxt            = h_r;
    wh_nxt           = wh_r;
    rem_lines_nxt    = rem_lines_r;
    room_nxt         = room_r;
    recalc_nxt       = (recalc_r != '0) ? recalc_r - 2'd1 : recalc_r;
    line_index_nxt   = line_index_r;
    line_base_nxt    = line_base_r;
    column_nxt       = column_r;
    phase_nxt        = phase_r;
    literal_left_nxt = literal_left_r;
    repeat_nxt       = repeat_r;

    cmd_push       = 1'b0;
    cmd.line_base  = line_base_r;
    cmd.col_lo     = ADDR_W'(column_r);
    cmd.value      = in_ch.chunk_byte;
    cmd.count      = RUN_W'(1);

    lit       = literal_left_r;
    col_after = column_r;
    adv       = 1'b0;

    // width and height are set, then their product and the lines left, then the space left
    if (cfg_wr) begin
      recalc_nxt = RECALC_CYCLES;
      unique case (reg_idx_t'(paddr[2]))
        REG_FRAME_WIDTH: begin
          frame_width_nxt = wdata;
          w_nxt = (wdata > CFG_W'(W_LIM)) ? CFG_W'(W_LIM) : wdata;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_nxt = wdata;
          h_nxt = (wdata > CFG_W'(H_LIM)) ? CFG_W'(H_LIM) : wdata;
        end
        default: ;
      endcase
    end else if (recalc_r == RECALC_CYCLES) begin
      wh_nxt        = ROOM_W'(w_r) * ROOM_W'(h_r);
      rem_lines_nxt = active ? h_r - line_index_r : '0;
    end else if (recalc_r != '0) begin
      room_nxt = ROOM_W'(w_r) * ROOM_W'(rem_lines_r);
    end

    if (accept && active) begin
      unique case (phase_r)
        PH_COUNT: begin
          phase_nxt = PH_OPCODE;
          adv = (column_r >= w_ext);
        end
        PH_OPCODE: begin
          if (in_ch.chunk_byte[OPC_LITERAL_BIT]) begin
            literal_left_nxt = LIT_W'(0) - LIT_W'(in_ch.chunk_byte);
            phase_nxt = PH_LITERAL;
          end else begin
            repeat_nxt = in_ch.chunk_byte[RUN_W-1:0];
            phase_nxt = PH_FILL;
          end
        end
        PH_LITERAL: begin
          if (col_lt_room) begin
            cmd_push  = 1'b1;
            col_after = col_inc;
            lit = (col_inc >= room_r) ? '0 : literal_left_r - LIT_W'(1);
          end else begin
            lit = '0;
          end
          literal_left_nxt = lit;
          column_nxt = col_after;
          if (lit == '0) begin
            phase_nxt = PH_OPCODE;
            adv = (col_after >= w_ext);
          end
        end
        PH_FILL: begin
          cmd_push   = (fill_len != '0);
          cmd.count  = fill_len;
          col_after  = column_r + ROOM_W'(fill_len);
          column_nxt = col_after;
          repeat_nxt = '0;
          phase_nxt  = PH_OPCODE;
          adv = (col_after >= w_ext);
        end
        default: ;
      endcase

      if (adv) begin
        line_index_nxt   = line_index_r + CFG_W'(1);
        line_base_nxt    = line_base_r + ADDR_W'(w_r);
        room_nxt         = room_r - w_ext;
        column_nxt       = '0;
        phase_nxt        = PH_COUNT;
        literal_left_nxt = '0;
        repeat_nxt       = '0;
      end
    end

    // end of chunk: back to the first line
    if (chunk_end) begin
      line_index_nxt   = '0;
      line_base_nxt    = '0;
      room_nxt         = wh_r;
      column_nxt       = '0;
      phase_nxt        = PH_COUNT;
      literal_left_nxt = '0;
      repeat_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W'(FRAME_WIDTH_RST);
      frame_height_r <= CFG_W'(FRAME_HEIGHT_RST);
      w_r            <= CFG_W'(RST_W);
      h_r            <= CFG_W'(RST_H);
      wh_r           <= ROOM_W'(RST_ROOM);
      rem_lines_r    <= CFG_W'(RST_H);
      room_r         <= ROOM_W'(RST_ROOM);
      recalc_r       <= '0;
      line_index_r   <= '0;
      line_base_r    <= '0;
      column_r       <= '0;
      phase_r        <= PH_COUNT;
      literal_left_r <= '0;
      repeat_r       <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      w_r            <= w_nxt;
      h_r            <= h_nxt;
      wh_r           <= wh_nxt;
      rem_lines_r    <= rem_lines_nxt;
      room_r         <= room_nxt;
      recalc_r       <= recalc_nxt;
      line_index_r   <= line_index_nxt;
      line_base_r    <= line_base_nxt;
      column_r       <= column_nxt;
      phase_r        <= phase_nxt;
      literal_left_r <= literal_left_nxt;
      repeat_r       <= repeat_nxt;
    end
  end

  `FBRD_ASSERT(a_cfg_holds_input, cfg_wr |=> !in_ch.ready)
  `FBRD_ASSERT(a_cmd_has_pixels, cmd_push |-> (cmd.count != '0) && accept)
  `FBRD_ASSERT(a_last_restarts, chunk_end |=> (line_index_r == '0) && (phase_r == PH_COUNT))

endmodule

`default_nettype wire

// File: rtl/core/fbrd_back.sv
// ----------------------------------------------------------------------------
// fbrd_back
// Output stage: forms the frame buffer address and holds the write request
// until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fbrd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire fbrd_pkg::cmd_t q_head,
  output logic                q_pop,
  fbrd_out_if.source          out_ch
);
  import fbrd_pkg::*;

  logic              valid_r, valid_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [BYTE_W-1:0] value_r, value_nxt;
  logic [RUN_W-1:0]  count_r, count_nxt;

  assign q_pop = q_valid & (~valid_r | out_ch.ready);

  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    value_nxt = value_r;
    count_nxt = count_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
      addr_nxt  = q_head.line_base + q_head.col_lo;
      value_nxt = q_head.value;
      count_nxt = q_head.count;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    value_r <= value_nxt;
    count_r <= count_nxt;
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.write_address = addr_r;
  assign out_ch.pixel_value   = value_r;
  assign out_ch.run_count     = count_r;

endmodule

`default_nettype wire

// File: rtl/core/fli_byte_run_decoder_top.sv
// ----------------------------------------------------------------------------
// fli_byte_run_decoder_top
// Byte-run chunk decoder: compressed bytes in, frame buffer writes out.
// ----------------------------------------------------------------------------
// in_ch takes one chunk byte per request; chunk_last marks the final byte,
// after which decoding restarts at the first line. out_ch gives one write
// request per literal byte (run_count 1) or per clipped fill (one request
// for the whole run); bytes that write nothing give no request.
// frame_width (0x0) and frame_height (0x4) are to be written over the APB
// port only while the decoder is idle; the user must keep to this, as the
// block does not enforce it. in_ch.ready then drops while the frame size
// products are rebuilt. in_ch takes one byte per cycle while in_ch.ready is
// high. A taken byte's request is written into the command queue, then the
// address add is registered into the output register that drives out_ch.
// Reset: 320 x 200 frame, first line, expecting the packet count byte.
// When out_ch stalls, the two-entry command queue and the output register
// fill, then in_ch.ready drops until the receiver takes a request.
// ----------------------------------------------------------------------------
`default_nettype none

module fli_byte_run_decoder_top #(
  parameter int unsigned MAX_LINE_PIXELS = fbrd_pkg::MAX_LINE_PIXELS_DEF,
  parameter int unsigned MAX_LINES       = fbrd_pkg::MAX_LINES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fbrd_in_if.sink                              in_ch,
  fbrd_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fbrd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [fbrd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [fbrd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import fbrd_pkg::*;

  logic cmd_push;
  cmd_t cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_head;

  fbrd_front #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
    .MAX_LINES       (MAX_LINES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cmd_push (cmd_push),
    .cmd      (cmd),
    .q_full   (q_full)
  );

  fbrd_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  fbrd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// File: verif/tb_fli_byte_run_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_fli_byte_run_decoder_top
// Self-checking bench for the byte-run chunk decoder.
// ----------------------------------------------------------------------------
// Chunk bytes are queued by the stimulus process and driven by a clocked
// driver; every accepted byte is decoded by a local predictor that keeps its
// own line, column and opcode state and queues the frame writes it expects.
// A clocked monitor pops each write request from out_ch and compares address,
// value and count. The run walks a series of frame sizes (reset size, tiny,
// zero, oversized) written over APB while the decoder is idle, with directed
// bytes first, then random chunks, broken chunks and noise.
// ----------------------------------------------------------------------------
module tb_fli_byte_run_decoder_top;
  import fbrd_pkg::*;

  localparam int unsigned N_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS = 135;
  localparam int unsigned CHUNK_CAP   = 60;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef enum logic [1:0] {
    DEC_COUNT,
    DEC_OPCODE,
    DEC_LITERAL,
    DEC_FILL
  } dec_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } chunk_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    logic [RUN_W-1:0]  count;
  } fb_write_t;

  logic clk;
  logic rst_n;

  fbrd_in_if  in_ch ();
  fbrd_out_if out_ch ();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fli_byte_run_decoder_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  chunk_item_t pending[$];
  fb_write_t   writes_due[$];
  int unsigned n_queued;
  int unsigned n_taken;
  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  int unsigned frame_w_set [N_PHASES] = '{320, 3, 1, 16, 0, 5, 4096, 8191, 1, 40, 2, 7};
  int unsigned frame_h_set [N_PHASES] = '{200, 2, 1, 4, 3, 0, 2, 8191, 4096, 6, 7, 9};

  // predictor copy of the registers and decoder state
  logic [CFG_W-1:0]  cfg_width  = CFG_W'(FRAME_WIDTH_RST);
  logic [CFG_W-1:0]  cfg_height = CFG_W'(FRAME_HEIGHT_RST);
  logic [CFG_W-1:0]  line_idx   = '0;
  logic [ADDR_W-1:0] line_base  = '0;
  int unsigned       col        = 0;
  dec_phase_t        dec_phase  = DEC_COUNT;
  logic [LIT_W-1:0]  lit_left   = '0;
  logic [RUN_W-1:0]  rep        = '0;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic int unsigned eff_width();
    return (cfg_width > MAX_LINE_PIXELS_DEF) ? MAX_LINE_PIXELS_DEF : cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height > MAX_LINES_DEF) ? MAX_LINES_DEF : cfg_height;
  endfunction

  function automatic void advance_line(input int unsigned w);
    line_idx  = CFG_W'(line_idx + 1);
    line_base = ADDR_W'(line_base + w);
    col       = 0;
    dec_phase = DEC_COUNT;
    lit_left  = '0;
    rep       = '0;
  endfunction

  function automatic void expect_write(input logic [BYTE_W-1:0] v, input int unsigned n);
    fb_write_t wr;
    wr.addr  = ADDR_W'(line_base + col);
    wr.value = v;
    wr.count = RUN_W'(n);
    writes_due.push_back(wr);
  endfunction

  function automatic void decode_chunk_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned w;
    int unsigned h;
    int unsigned room;
    int unsigned len;
    w = eff_width();
    h = eff_height();
    if (line_idx < h) begin
      room = w * (h - line_idx);
      case (dec_phase)
        DEC_COUNT: begin
          dec_phase = DEC_OPCODE;
          if (col >= w) advance_line(w);
        end
        DEC_OPCODE: begin
          if (b[OPC_LITERAL_BIT]) begin
            lit_left  = LIT_W'(256 - b);
            dec_phase = DEC_LITERAL;
          end else begin
            rep       = b[RUN_W-1:0];
            dec_phase = DEC_FILL;
          end
        end
        DEC_LITERAL: begin
          if (col < room) begin
            expect_write(b, 1);
            col++;
            lit_left = lit_left - 1'b1;
            if (col >= room) lit_left = '0;
          end else begin
            lit_left = '0;
          end
          if (lit_left == '0) begin
            dec_phase = DEC_OPCODE;
            if (col >= w) advance_line(w);
          end
        end
        default: begin
          len = 0;
          if (col < room) len = (rep < room - col) ? rep : room - col;
          if (len != 0) expect_write(b, len);
          col += len;
          rep       = '0;
          dec_phase = DEC_OPCODE;
          if (col >= w) advance_line(w);
        end
      endcase
    end
    if (last) begin
      line_idx  = '0;
      line_base = '0;
      col       = 0;
      dec_phase = DEC_COUNT;
      lit_left  = '0;
      rep       = '0;
    end
  endfunction

  function automatic void queue_byte(input logic [BYTE_W-1:0] b, input logic last);
    pending.push_back({b, last});
    n_queued++;
  endfunction

  // well-formed chunk sized to the current frame; cut drops the tail and
  // leaves the chunk open
  function automatic void queue_chunk(input bit cut);
    chunk_item_t stage[$];
    int unsigned w;
    int unsigned h;
    int unsigned nlines;
    int unsigned c;
    int unsigned len;
    int unsigned keep;
    w = eff_width();
    h = eff_height();
    nlines = $urandom_range(((h < 4) ? h : 4) + 1, 1);
    for (int unsigned ln = 0; ln < nlines && stage.size() < CHUNK_CAP; ln++) begin
      stage.push_back({8'($urandom), 1'b0});
      c = 0;
      while (c < w && stage.size() < CHUNK_CAP) begin
        if ($urandom_range(1) == 1) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(128, 1) : $urandom_range(6, 1);
          stage.push_back({8'(256 - len), 1'b0});
          repeat (len) stage.push_back({8'($urandom), 1'b0});
        end else begin
          len = ($urandom_range(7) == 0) ? 0 : $urandom_range(127, 1);
          stage.push_back({8'(len), 1'b0});
          stage.push_back({8'($urandom), 1'b0});
        end
        c += len;
      end
    end
    if (cut) begin
      keep = $urandom_range(stage.size(), 1);
      while (stage.size() > keep) void'(stage.pop_back());
    end else if ($urandom_range(9) != 0) begin
      stage[stage.size()-1].last = 1'b1;
    end
    foreach (stage[i]) queue_byte(stage[i].data, stage[i].last);
  endfunction

  task automatic wait_idle();
    while (pending.size() != 0 || n_taken != n_queued || writes_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * idx);
    pwdata  <= {(APB_DATA_W-CFG_W)'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_width = val;
    else cfg_height = val;
  endtask

  // driver: chunk bytes
  always @(posedge clk) begin
    chunk_item_t nxt;
    if (in_ch.valid && in_ch.ready) begin
      decode_chunk_byte(in_ch.chunk_byte, in_ch.chunk_last);
      n_taken++;
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.chunk_byte <= nxt.data;
        in_ch.chunk_last <= nxt.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: frame writes
  always @(posedge clk) begin
    fb_write_t exp_wr;
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (writes_due.size() == 0) begin
        $display("%0t: unexpected write request addr %h value %h count %0d", $time,
                 out_ch.write_address, out_ch.pixel_value, out_ch.run_count);
        mismatches++;
      end else begin
        exp_wr = writes_due.pop_front();
        if (out_ch.write_address !== exp_wr.addr) begin
          $display("%0t: write_address expected %h got %h", $time, exp_wr.addr,
                   out_ch.write_address);
          mismatches++;
        end
        if (out_ch.pixel_value !== exp_wr.value) begin
          $display("%0t: pixel_value expected %h got %h", $time, exp_wr.value,
                   out_ch.pixel_value);
          mismatches++;
        end
        if (out_ch.run_count !== exp_wr.count) begin
          $display("%0t: run_count expected %0d got %0d", $time, exp_wr.count,
                   out_ch.run_count);
          mismatches++;
        end
      end
    end
  end

  // no request on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [BYTE_W-1:0] dir_rst  [12] = '{8'hFF, 8'h00, 8'h12, 8'h7F, 8'hFF, 8'hFF,
                                         8'h00, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'h55};
    logic [BYTE_W-1:0] dir_clip [10] = '{8'h00, 8'h7F, 8'hA5, 8'h3C, 8'hFB,
                                         8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    int unsigned start;
    in_ch.valid      = 1'b0;
    in_ch.chunk_byte = '0;
    in_ch.chunk_last = 1'b0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    n_queued         = 0;
    n_taken          = 0;
    mismatches       = 0;
    stall_cycles     = 0;
    send_idle_pct    = 18;
    recv_idle_pct    = 58;
    rst_n            = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(frame_w_set[p]));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(frame_h_set[p]));
      end
      send_idle_pct = (p < 4) ? 18 : (p < 8) ? 58 : 0;
      recv_idle_pct = (p < 4) ? 58 : (p < 8) ? 18 : 0;
      // reset frame: zero fill, max fill, one- and two-byte literals
      if (p == 0) foreach (dir_rst[i]) queue_byte(dir_rst[i], i == 11);
      // 3x2 frame: fill clipped at frame end, literal cut at frame end
      if (p == 1) foreach (dir_clip[i]) queue_byte(dir_clip[i], i == 9);
      start = n_queued;
      while (n_queued - start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(12, 1))
            queue_byte(8'($urandom), $urandom_range(7) == 0);
        end else begin
          queue_chunk(1'b0);
        end
      end
      // leave a chunk open across the register change
      queue_chunk(1'b1);
    end

    wait_idle();
    if (mismatches == 0 && writes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
